/* sv/hs_pkg.sv */
package hs_pkg;

	localparam int WORD_W    = 32;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_NODE,
		ST_NODE_W,
		ST_CHILD,
		ST_LC,
		ST_RC,
		ST_DEC,
		ST_SWAP,
		ST_NEXT,
		ST_XR0,
		ST_XR1,
		ST_XW0,
		ST_XW1,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} state_t;

endpackage

/* sv/hs_if.sv */
interface hs_in_if import hs_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] value_in;
	logic                     last_in;

	modport source (output valid, value_in, last_in, input ready);
	modport sink (input valid, value_in, last_in, output ready);
endinterface

interface hs_out_if import hs_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] sorted_value;
	logic                     last_out;
	logic                     overflow;

	modport source (output valid, sorted_value, last_out, overflow, input ready);
	modport sink (input valid, sorted_value, last_out, overflow, output ready);
endinterface

/* sv/heap_sorter_top.sv */
// Heap sorter: collects up to DEPTH signed 32-bit words, one per cycle, and
// on the word flagged last_in sorts them in place with a max-heap in a
// memory with one read and one write port and streams them out in ascending
// order, last_out on the final word and overflow on every word of a set that
// lost words beyond DEPTH. The sort runs under a small sequencer, with the
// input held off. Results then leave one at a time when the sink is ready,
// valid dropping after each word is taken while the next is read; input is
// taken again once the final word has been taken.
module heap_sorter_top import hs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hs_in_if.sink     in_ch,
	hs_out_if.source  out_ch
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = AW + 2;

	state_t st_q, st_d;

	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rd_q;
	logic signed [WORD_W-1:0] nv_q;
	logic signed [WORD_W-1:0] best_val_q;
	logic signed [WORD_W-1:0] out_val_q;
	logic                     out_last_q;
	logic                     out_ovf_q;
	logic                     out_v_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] sz_q;
	logic [AW-1:0] node_q;
	logic [AW-1:0] par_q;
	logic [AW-1:0] best_idx_q;
	logic [AW-1:0] emit_q;
	logic          drop_q;
	logic          build_q;

	logic [AW-1:0]           rd_addr;
	logic                    we;
	logic [AW-1:0]           wa;
	logic signed [WORD_W-1:0] wd;

	logic [LW-1:0] lc, rc, sz_l;
	logic [AW-1:0] par_init;
	logic [AW-1:0] last_idx;
	logic          in_acc, out_acc;

	assign lc       = LW'({node_q, 1'b1});
	assign rc       = lc + LW'(1);
	assign sz_l     = LW'(sz_q);
	assign par_init = AW'((cnt_q >> 1) - CW'(1));
	assign last_idx = AW'(sz_q - CW'(1));

	assign in_ch.ready = (st_q == ST_LOAD);
	assign in_acc      = in_ch.valid && in_ch.ready;

	assign out_ch.valid        = out_v_q;
	assign out_ch.sorted_value = out_val_q;
	assign out_ch.last_out     = out_last_q;
	assign out_ch.overflow     = out_ovf_q;
	assign out_acc             = out_v_q && out_ch.ready;

	// storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d    = st_q;
		rd_addr = node_q;
		we      = 1'b0;
		wa      = node_q;
		wd      = best_val_q;
		case (st_q)
			ST_LOAD: begin
				if (in_acc) begin
					we = (cnt_q < CW'(DEPTH));
					wa = AW'(cnt_q);
					wd = in_ch.value_in;
					if (in_ch.last_in) begin
						st_d = ST_START;
					end
				end
			end
			ST_START: begin
				st_d = (cnt_q < CW'(2)) ? ST_EMIT_RD : ST_NODE;
			end
			ST_NODE: begin
				rd_addr = node_q;
				st_d    = ST_NODE_W;
			end
			ST_NODE_W: begin
				st_d = ST_CHILD;
			end
			ST_CHILD: begin
				rd_addr = lc[AW-1:0];
				st_d    = (lc < sz_l) ? ST_LC : ST_NEXT;
			end
			ST_LC: begin
				rd_addr = rc[AW-1:0];
				st_d    = (rc < sz_l) ? ST_RC : ST_DEC;
			end
			ST_RC: begin
				st_d = ST_DEC;
			end
			ST_DEC: begin
				if (best_idx_q == node_q) begin
					st_d = ST_NEXT;
				end else begin
					we   = 1'b1;
					wa   = node_q;
					wd   = best_val_q;
					st_d = ST_SWAP;
				end
			end
			ST_SWAP: begin
				we   = 1'b1;
				wa   = best_idx_q;
				wd   = nv_q;
				st_d = ST_CHILD;
			end
			ST_NEXT: begin
				if (build_q && (par_q != '0)) begin
					st_d = ST_NODE;
				end else if (sz_q > CW'(1)) begin
					st_d = ST_XR0;
				end else begin
					st_d = ST_EMIT_RD;
				end
			end
			ST_XR0: begin
				rd_addr = '0;
				st_d    = ST_XR1;
			end
			ST_XR1: begin
				rd_addr = last_idx;
				st_d    = ST_XW0;
			end
			ST_XW0: begin
				we   = 1'b1;
				wa   = '0;
				wd   = rd_q;
				st_d = ST_XW1;
			end
			ST_XW1: begin
				we   = 1'b1;
				wa   = last_idx;
				wd   = nv_q;
				st_d = ST_NODE;
			end
			ST_EMIT_RD: begin
				rd_addr = emit_q;
				st_d    = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				st_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (out_acc) begin
					if (out_last_q) begin
						st_d = ST_LOAD;
					end else begin
						rd_addr = emit_q;
						st_d    = ST_EMIT_LD;
					end
				end
			end
			default: begin
				st_d = ST_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sz_q    <= '0;
			node_q  <= '0;
			par_q   <= '0;
			emit_q  <= '0;
			drop_q  <= 1'b0;
			build_q <= 1'b0;
			out_v_q <= 1'b0;
			best_idx_q <= '0;
		end else begin
			case (st_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q < CW'(DEPTH)) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					sz_q    <= cnt_q;
					node_q  <= par_init;
					par_q   <= par_init;
					build_q <= 1'b1;
					emit_q  <= '0;
				end
				ST_NODE_W: begin
					best_idx_q <= node_q;
				end
				ST_LC: begin
					if (rd_q > best_val_q) begin
						best_idx_q <= lc[AW-1:0];
					end
				end
				ST_RC: begin
					if (rd_q > best_val_q) begin
						best_idx_q <= rc[AW-1:0];
					end
				end
				ST_SWAP: begin
					node_q <= best_idx_q;
				end
				ST_NEXT: begin
					if (build_q && (par_q != '0)) begin
						par_q  <= par_q - AW'(1);
						node_q <= par_q - AW'(1);
					end else begin
						build_q <= 1'b0;
					end
				end
				ST_XW1: begin
					sz_q   <= sz_q - CW'(1);
					node_q <= '0;
				end
				ST_EMIT_LD: begin
					out_v_q <= 1'b1;
					emit_q  <= emit_q + AW'(1);
				end
				ST_EMIT_WAIT: begin
					if (out_acc) begin
						out_v_q <= 1'b0;
						if (out_last_q) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_NODE_W: begin
				nv_q       <= rd_q;
				best_val_q <= rd_q;
			end
			ST_LC, ST_RC: begin
				if (rd_q > best_val_q) begin
					best_val_q <= rd_q;
				end
			end
			ST_SWAP: begin
				best_val_q <= nv_q;
			end
			ST_XR1: begin
				nv_q <= rd_q;
			end
			ST_EMIT_LD: begin
				out_val_q  <= rd_q;
				out_last_q <= (LW'(emit_q) + LW'(1) == LW'(cnt_q));
				out_ovf_q  <= drop_q;
			end
			default: begin
			end
		endcase
	end

endmodule
